FILE: hdl/dsbc_pkg.sv
// Shared constants, codes and types of the drive-state PI/brake controller.
`default_nettype none

package dsbc_pkg;

  // Speed fields are clamped to this magnitude before the error is formed.
  localparam int unsigned SpeedMax  = 100;
  // Full brake application in percent.
  localparam int unsigned BrakeFull = 100;

  // Configuration port geometry.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CFG_PROP_GAIN   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_INTEG_GAIN  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RAMP_STEP   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PREPARE_MS  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_ZERO_CONF   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_BRAKE_THR   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_BRAKE_GAIN  = 3'd6;

  // Register reset values.
  localparam logic [15:0] RST_PROP_GAIN  = 16'd640;
  localparam logic [15:0] RST_INTEG_GAIN = 16'd13;
  localparam logic [6:0]  RST_RAMP_STEP  = 7'd15;
  localparam logic [15:0] RST_PREPARE_MS = 16'd400;
  localparam logic [7:0]  RST_ZERO_CONF  = 8'd3;
  localparam logic [6:0]  RST_BRAKE_THR  = 7'd8;
  localparam logic [6:0]  RST_BRAKE_GAIN = 7'd6;

  // Drive state codes.
  localparam logic [1:0] DRIVE_IDLE   = 2'd0;
  localparam logic [1:0] DRIVE_PREP   = 2'd1;
  localparam logic [1:0] DRIVE_CRUISE = 2'd2;
  localparam logic [1:0] DRIVE_DECEL  = 2'd3;

  // Deceleration sub-mode codes.
  localparam logic [1:0] DECEL_NONE  = 2'd0;
  localparam logic [1:0] DECEL_COAST = 2'd1;
  localparam logic [1:0] DECEL_BRAKE = 2'd2;

  // The brake release quotient stays below 100, so seven bits are resolved.
  localparam int unsigned DivSteps = 7;
  localparam int unsigned DivCntW  = 3;

  typedef struct packed {
    logic signed [7:0] speed_setpoint;
    logic [6:0]        measured_speed;
    logic [9:0]        tick_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0] drive_state;
    logic [1:0] decel_mode;
    logic [6:0] motor_command;
    logic [6:0] brake_percent;
    logic       gear_forward;
  } out_item_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic eval;
    logic div_step;
    logic mul_i;
    logic fin;
    logic emit;
  } cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic div_needed;
    logic pi_needed;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: hdl/dsbc_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
`default_nettype none

interface dsbc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/dsbc_ctrl.sv
// Sequencer that steps one control tick through the datapath.
`default_nettype none

module dsbc_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire dsbc_pkg::sts_t sts_i,
  output dsbc_pkg::cmd_t      cmd_o
);

  localparam logic [2:0] ST_WAIT = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MULI = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_PUT  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == ST_WAIT);
    unique case (state_q)
      ST_WAIT: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        priority if (sts_i.div_needed) begin
          state_d = ST_DIV;
        end else if (sts_i.pi_needed) begin
          state_d = ST_MULI;
        end else begin
          state_d = ST_PUT;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_PUT;
        end
      end
      ST_MULI: begin
        cmd_o.mul_i = 1'b1;
        state_d     = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_PUT;
      end
      ST_PUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_WAIT;
        end
      end
      default: begin
        state_d = ST_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_WAIT;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  a_cmd_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.eval, cmd_o.div_step, cmd_o.mul_i, cmd_o.fin, cmd_o.emit}))
    else $error("More than one datapath command in one cycle.");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> !in_ready_o)
    else $error("Second tick taken while the first is still in work.");
  a_path_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> !(sts_i.div_needed && sts_i.pi_needed))
    else $error("Tick asks for both the divider and the PI path.");
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && sts_i.div_last) |=> (state_q == ST_PUT))
    else $error("Divider finished but result was not handed off.");
`endif

endmodule

`default_nettype wire

FILE: hdl/dsbc_dp.sv
// Datapath: configuration, drive state, PI arithmetic, divider and result register.
`default_nettype none

module dsbc_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [dsbc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [dsbc_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire dsbc_pkg::in_item_t              in_data_i,
  output dsbc_pkg::out_item_t                  out_data_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  input  wire dsbc_pkg::cmd_t                  cmd_i,
  output dsbc_pkg::sts_t                       sts_o
);

  // Configuration registers.
  logic [15:0] kp_q, ki_q, prep_ms_q;
  logic [6:0]  ramp_q, bthr_q, bgain_q;
  logic [7:0]  zconf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q      <= dsbc_pkg::RST_PROP_GAIN;
      ki_q      <= dsbc_pkg::RST_INTEG_GAIN;
      ramp_q    <= dsbc_pkg::RST_RAMP_STEP;
      prep_ms_q <= dsbc_pkg::RST_PREPARE_MS;
      zconf_q   <= dsbc_pkg::RST_ZERO_CONF;
      bthr_q    <= dsbc_pkg::RST_BRAKE_THR;
      bgain_q   <= dsbc_pkg::RST_BRAKE_GAIN;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dsbc_pkg::CFG_PROP_GAIN:  kp_q      <= cfg_data_i;
        dsbc_pkg::CFG_INTEG_GAIN: ki_q      <= cfg_data_i;
        dsbc_pkg::CFG_RAMP_STEP:  ramp_q    <= cfg_data_i[6:0];
        dsbc_pkg::CFG_PREPARE_MS: prep_ms_q <= cfg_data_i;
        dsbc_pkg::CFG_ZERO_CONF:  zconf_q   <= cfg_data_i[7:0];
        dsbc_pkg::CFG_BRAKE_THR:  bthr_q    <= cfg_data_i[6:0];
        dsbc_pkg::CFG_BRAKE_GAIN: bgain_q   <= cfg_data_i[6:0];
        default: begin
        end
      endcase
    end
  end

  // Input capture: clamp both speeds and form the error.
  logic [7:0] tgt_u, tgt_neg, tmag_raw;
  logic [6:0] tmag_c, meas_c;
  logic [7:0] err_raw;

  always_comb begin
    tgt_u    = in_data_i.speed_setpoint;
    tgt_neg  = 8'd0 - tgt_u;
    tmag_raw = tgt_u[7] ? tgt_neg : tgt_u;
    tmag_c   = (tmag_raw > 8'(dsbc_pkg::SpeedMax)) ? 7'(dsbc_pkg::SpeedMax) : tmag_raw[6:0];
    meas_c   = (in_data_i.measured_speed > 7'(dsbc_pkg::SpeedMax)) ?
               7'(dsbc_pkg::SpeedMax) : in_data_i.measured_speed;
    err_raw  = {1'b0, tmag_c} - {1'b0, meas_c};
  end

  logic              tgt_nz_q, tgt_neg_q, meas_zero_q;
  logic signed [7:0] err_q;
  logic [9:0]        tick_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tgt_nz_q    <= (tgt_u != 8'd0);
      tgt_neg_q   <= tgt_u[7];
      meas_zero_q <= (meas_c == 7'd0);
      err_q       <= $signed(err_raw);
      tick_q      <= in_data_i.tick_ms;
    end
  end

  // Drive state.
  logic [1:0]         mode_q, sub_q;
  logic [15:0]        elapsed_q;
  logic [6:0]         pbrake_q;
  logic [7:0]         streak_q;
  logic signed [15:0] esum_q;
  logic [6:0]         last_q;
  logic               gear_q;

  // Tick evaluation: state transition followed by the per-state outputs.
  logic [7:0]         err_neg;
  logic [6:0]         abs_e;
  logic               err_lt_m1;
  logic [1:0]         dsub;
  logic [16:0]        el_sum;
  logic [15:0]        el_sat;
  logic [7:0]         streak_inc;
  logic [13:0]        brake_prod;
  logic [6:0]         brake_calc;
  logic [1:0]         mode_n, sub_n;
  logic [15:0]        elapsed_n;
  logic [6:0]         pbrake_n;
  logic [7:0]         streak_n;
  logic               gear_n, esum_clr, div_needed, pi_needed, last_clr;
  logic signed [16:0] esum_add;
  logic signed [15:0] esum_n;
  logic [6:0]         brake_n;

  always_comb begin
    err_neg    = 8'd0 - err_q;
    abs_e      = err_q[7] ? err_neg[6:0] : err_q[6:0];
    err_lt_m1  = (err_q < -8'sd1);
    dsub       = (abs_e > bthr_q) ? dsbc_pkg::DECEL_BRAKE : dsbc_pkg::DECEL_COAST;
    el_sum     = {1'b0, elapsed_q} + {7'd0, tick_q};
    el_sat     = el_sum[16] ? 16'hFFFF : el_sum[15:0];
    streak_inc = meas_zero_q ? ((streak_q == 8'hFF) ? streak_q : streak_q + 8'd1) : 8'd0;
    brake_prod = abs_e * bgain_q;
    brake_calc = (brake_prod > 14'(dsbc_pkg::BrakeFull)) ?
                 7'(dsbc_pkg::BrakeFull) : brake_prod[6:0];

    mode_n     = mode_q;
    sub_n      = sub_q;
    elapsed_n  = elapsed_q;
    pbrake_n   = pbrake_q;
    streak_n   = streak_q;
    gear_n     = gear_q;
    esum_clr   = 1'b0;
    div_needed = 1'b0;

    unique case (mode_q)
      dsbc_pkg::DRIVE_IDLE: begin
        if (tgt_nz_q) begin
          mode_n    = dsbc_pkg::DRIVE_PREP;
          elapsed_n = 16'd0;
          pbrake_n  = 7'(dsbc_pkg::BrakeFull);
          gear_n    = !tgt_neg_q;
        end
      end
      dsbc_pkg::DRIVE_PREP: begin
        if (!tgt_nz_q) begin
          mode_n = dsbc_pkg::DRIVE_IDLE;
        end else begin
          elapsed_n = el_sat;
          if (el_sat >= prep_ms_q) begin
            pbrake_n = 7'd0;
            mode_n   = dsbc_pkg::DRIVE_CRUISE;
            esum_clr = 1'b1;
          end else begin
            div_needed = 1'b1;
          end
        end
      end
      dsbc_pkg::DRIVE_CRUISE: begin
        if (!tgt_nz_q) begin
          mode_n   = dsbc_pkg::DRIVE_DECEL;
          sub_n    = dsbc_pkg::DECEL_BRAKE;
          streak_n = 8'd0;
        end else if (err_lt_m1) begin
          mode_n   = dsbc_pkg::DRIVE_DECEL;
          sub_n    = dsub;
          streak_n = 8'd0;
        end
      end
      default: begin
        if (streak_inc >= zconf_q) begin
          mode_n   = dsbc_pkg::DRIVE_IDLE;
          sub_n    = dsbc_pkg::DECEL_NONE;
          streak_n = 8'd0;
        end else if (tgt_nz_q && !err_lt_m1) begin
          mode_n   = dsbc_pkg::DRIVE_CRUISE;
          sub_n    = dsbc_pkg::DECEL_NONE;
          streak_n = 8'd0;
        end else begin
          sub_n    = dsub;
          streak_n = streak_inc;
        end
      end
    endcase

    // Integral update with symmetric saturation.
    esum_add = (esum_clr ? 17'sd0 : $signed({esum_q[15], esum_q}))
             + $signed({{9{err_q[7]}}, err_q});
    if (esum_add > 17'sd32767) begin
      esum_add = 17'sd32767;
    end else if (esum_add < -17'sd32767) begin
      esum_add = -17'sd32767;
    end

    esum_n    = esum_q;
    brake_n   = 7'd0;
    pi_needed = 1'b0;
    last_clr  = 1'b0;
    unique case (mode_n)
      dsbc_pkg::DRIVE_IDLE: begin
        brake_n  = 7'(dsbc_pkg::BrakeFull);
        esum_n   = 16'sd0;
        last_clr = 1'b1;
      end
      dsbc_pkg::DRIVE_PREP: begin
        brake_n  = pbrake_n;
        last_clr = 1'b1;
      end
      dsbc_pkg::DRIVE_CRUISE: begin
        esum_n    = esum_add[15:0];
        pi_needed = 1'b1;
      end
      default: begin
        esum_n  = 16'sd0;
        brake_n = (sub_n == dsbc_pkg::DECEL_BRAKE) ? brake_calc : 7'd0;
      end
    endcase
  end

  // Restoring divider for the brake release: floor(elapsed * 100 / prepare_ms).
  logic [22:0]                  rem_q;
  logic [6:0]                   quo_q;
  logic [dsbc_pkg::DivCntW-1:0] dcnt_q;
  logic [22:0]                  el_x100, dsh;
  logic [23:0]                  trial;
  logic [6:0]                   quo_n;

  always_comb begin
    el_x100 = ({7'd0, el_sat} << 6) + ({7'd0, el_sat} << 5) + ({7'd0, el_sat} << 2);
    dsh     = {7'd0, prep_ms_q} << dcnt_q;
    trial   = {1'b0, rem_q} - {1'b0, dsh};
    quo_n   = quo_q | (trial[23] ? 7'd0 : (7'd1 << dcnt_q));
  end

  // PI arithmetic.
  logic signed [24:0] prod_p_q;
  logic signed [32:0] prod_i_q;
  logic signed [33:0] acc;
  logic               acc_pos;
  logic [6:0]         motor_raw, motor;
  logic [7:0]         lim;
  logic [6:0]         res_motor_q, res_brake_q;

  always_comb begin
    acc       = $signed({{9{prod_p_q[24]}}, prod_p_q}) + $signed({prod_i_q[32], prod_i_q});
    acc_pos   = !acc[33] && (acc != 34'sd0);
    motor_raw = (acc[32:7] > 26'(dsbc_pkg::SpeedMax)) ? 7'(dsbc_pkg::SpeedMax) : acc[13:7];
    lim       = {1'b0, last_q} + {1'b0, ramp_q};
    motor     = acc_pos ? (({1'b0, motor_raw} > lim) ? lim[6:0] : motor_raw) : 7'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= dsbc_pkg::DRIVE_IDLE;
      sub_q     <= dsbc_pkg::DECEL_NONE;
      elapsed_q <= 16'd0;
      pbrake_q  <= 7'(dsbc_pkg::BrakeFull);
      streak_q  <= 8'd0;
      esum_q    <= 16'sd0;
      last_q    <= 7'd0;
      gear_q    <= 1'b1;
      dcnt_q    <= '0;
    end else begin
      if (cmd_i.eval) begin
        mode_q    <= mode_n;
        sub_q     <= sub_n;
        elapsed_q <= elapsed_n;
        pbrake_q  <= pbrake_n;
        streak_q  <= streak_n;
        esum_q    <= esum_n;
        gear_q    <= gear_n;
        if (last_clr) begin
          last_q <= 7'd0;
        end
        if (div_needed) begin
          dcnt_q <= dsbc_pkg::DivCntW'(dsbc_pkg::DivSteps - 1);
        end
      end
      if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q - 1'b1;
        if (dcnt_q == '0) begin
          pbrake_q <= 7'(dsbc_pkg::BrakeFull) - quo_n;
        end
      end
      if (cmd_i.fin) begin
        last_q <= motor;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      prod_p_q    <= $signed({1'b0, kp_q}) * err_q;
      res_brake_q <= brake_n;
      res_motor_q <= 7'd0;
      if (div_needed) begin
        rem_q <= el_x100;
        quo_q <= 7'd0;
      end
    end
    if (cmd_i.div_step) begin
      quo_q <= quo_n;
      if (!trial[23]) begin
        rem_q <= trial[22:0];
      end
      if (dcnt_q == '0) begin
        res_brake_q <= 7'(dsbc_pkg::BrakeFull) - quo_n;
      end
    end
    if (cmd_i.mul_i) begin
      prod_i_q <= $signed({1'b0, ki_q}) * esum_q;
    end
    if (cmd_i.fin) begin
      res_motor_q <= motor;
    end
  end

  // Result register: decouples the result from the next tick's work.
  logic                out_valid_q;
  dsbc_pkg::out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.drive_state   <= mode_q;
      out_q.decel_mode    <= sub_q;
      out_q.motor_command <= res_motor_q;
      out_q.brake_percent <= res_brake_q;
      out_q.gear_forward  <= gear_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    sts_o.div_needed = div_needed;
    sts_o.pi_needed  = pi_needed;
    sts_o.div_last   = (dcnt_q == '0);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

FILE: hdl/drive_state_pi_brake_controller.sv
// Top level of the drive-state PI/brake controller.
`default_nettype none

// Each control tick arrives as one transfer on in_i (signed target speed, measured
// speed, milliseconds since the last tick) and produces exactly one transfer on
// out_o (drive state, deceleration sub-mode, motor command, brake percent, gear).
// Ticks are processed one at a time by a small sequencer driving a datapath.
// A tick runs from the wait state, where it is taken, through evaluation to the
// put state, where its result is loaded into the result register, when it ends in
// idle, decelerating or in preparing without a release step. When it ends in
// cruising, states for the integral product and for the final sum with clamp and
// slew limit come between evaluation, which forms the proportional product, and
// put. While the brake is still being released in preparing, a restoring divider
// resolves the seven quotient bits of the release ramp one per cycle between
// evaluation and put. The next tick can be taken in the cycle after the put state.
// The result sits in an output register, so the next tick can be taken
// while that result waits; a tick that finishes before the previous result has
// been taken waits for it. Configuration registers are written through
// cfg_we_i/cfg_idx_i/cfg_data_i and must only be changed while no tick is in work;
// an index with no register behind it is ignored.
module drive_state_pi_brake_controller (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  dsbc_stream_if.sink                        in_i,
  dsbc_stream_if.source                      out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [dsbc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [dsbc_pkg::CfgDataW-1:0] cfg_data_i
);

  dsbc_pkg::cmd_t      cmd;
  dsbc_pkg::sts_t      sts;
  logic                in_ready;
  logic                out_valid;
  dsbc_pkg::out_item_t out_data;

  // The sequencer owns the input handshake and decides the path of each tick.
  dsbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds configuration, drive state and the result register.
  dsbc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_i.data),
    .out_data_o  (out_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

endmodule

`default_nettype wire
